// ===== rtl/core/ttuv_pkg.sv =====
package ttuv_pkg;

    // Field widths
    localparam int POS_W = 32;
    localparam int UV_W  = 24;
    localparam int TAN_W = 16;

    // Edge and texture-edge widths (one bit of growth from the subtraction)
    localparam int E_W   = POS_W + 1;
    localparam int D_W   = UV_W + 1;
    localparam int DET_W = 2 * D_W + 1;
    localparam int T_W   = E_W + D_W + 1;
    localparam int MAG_W = T_W;

    // Normalised magnitudes are held below 2^NRM_W
    localparam int NRM_W  = 30;
    localparam int CSH    = 8;
    localparam int S_W    = 2 * NRM_W + 2;
    localparam int ROOT_W = NRM_W + 1;
    localparam int SQ_ITER = S_W / 2;

    // Quotient of (n << FRAC_W) / root never exceeds 2^FRAC_W
    localparam int FRAC_W = TAN_W - 2;
    localparam int QUO_W  = FRAC_W + 1;
    localparam int ONE_Q  = 2 ** FRAC_W;

    // Shared multiplier and subtractor
    localparam int MUL_W  = (E_W > NRM_W + 1) ? E_W : NRM_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUB_W  = ROOT_W + 3;

    // Sequencer counters
    localparam int N_T_OPS = 8;
    localparam int N_S_OPS = 3;
    localparam int OP_W    = $clog2(N_T_OPS + 1);
    localparam int CNT_W   = $clog2((SQ_ITER > QUO_W) ? SQ_ITER : QUO_W);

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] mul_prod_t;

endpackage

// ===== rtl/core/ttuv_mul.sv =====
module ttuv_mul import ttuv_pkg::*; (
    input  logic      aclk,
    input  mul_op_t   mul_a,
    input  mul_op_t   mul_b,
    output mul_prod_t mul_prod
);

    mul_prod_t prod_reg;
    mul_prod_t prod_next;

    // full-width signed product, registered
    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign mul_prod = prod_reg;

endmodule

// ===== rtl/core/triangle_tangent_from_uv_top.sv =====
// The first two vertices of a triangle are stored and give no word; the third starts the work.
// A zero det or tangent ends the work early with a degenerate word of zero tangent.
// No vertex is taken until the word of the last triangle has gone to the output register;
// the 31-step square root and three 15-step divisions share one subtractor.
// Reset: aresetn is synchronous, active low; it empties the output and restarts at vertex 0.
module triangle_tangent_from_uv_top import ttuv_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    // vertex words in
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [POS_W-1:0] s_pos_x,
    input  logic signed [POS_W-1:0] s_pos_y,
    input  logic signed [POS_W-1:0] s_pos_z,
    input  logic signed [UV_W-1:0]  s_tex_u,
    input  logic signed [UV_W-1:0]  s_tex_v,
    // tangent words out
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [TAN_W-1:0] m_tangent_x,
    output logic signed [TAN_W-1:0] m_tangent_y,
    output logic signed [TAN_W-1:0] m_tangent_z,
    output logic                    m_degenerate
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;  // taking vertices
    localparam logic [3:0] ST_MUL_T  = 4'd1;  // det and tangent products
    localparam logic [3:0] ST_CHECK  = 4'd2;  // degenerate test, magnitudes
    localparam logic [3:0] ST_SHIFT  = 4'd3;  // bring magnitudes below 2^NRM_W
    localparam logic [3:0] ST_MUL_S  = 4'd4;  // sum of squares
    localparam logic [3:0] ST_SQRT   = 4'd5;  // restoring square root
    localparam logic [3:0] ST_DIV_LD = 4'd6;  // load one component's division
    localparam logic [3:0] ST_DIV    = 4'd7;  // restoring division
    localparam logic [3:0] ST_FIN    = 4'd8;  // hand over to output register

    logic [3:0] state_reg, state_next;
    logic [1:0] slot_reg, slot_next;

    // first two vertices of the triangle
    logic signed [POS_W-1:0] hp_reg  [2][3];
    logic signed [POS_W-1:0] hp_next [2][3];
    logic signed [UV_W-1:0]  hu_reg  [2];
    logic signed [UV_W-1:0]  hu_next [2];
    logic signed [UV_W-1:0]  hv_reg  [2];
    logic signed [UV_W-1:0]  hv_next [2];

    // edges
    logic signed [E_W-1:0] e1_reg [3];
    logic signed [E_W-1:0] e1_next[3];
    logic signed [E_W-1:0] e2_reg [3];
    logic signed [E_W-1:0] e2_next[3];
    logic signed [D_W-1:0] du1_reg, du1_next, dv1_reg, dv1_next;
    logic signed [D_W-1:0] du2_reg, du2_next, dv2_reg, dv2_next;

    // products and normalisation
    logic signed [DET_W-1:0] det_reg, det_next;
    logic signed [T_W-1:0]   t_reg  [3];
    logic signed [T_W-1:0]   t_next [3];
    logic [MAG_W-1:0]        n_reg  [3];
    logic [MAG_W-1:0]        n_next [3];
    logic                    neg_reg [3];
    logic                    neg_next[3];
    logic [S_W-1:0]          s_reg, s_next;
    logic [ROOT_W:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [QUO_W-1:0]        dq_reg, dq_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [1:0]              comp_reg, comp_next;
    logic signed [TAN_W-1:0] res_reg [3];
    logic signed [TAN_W-1:0] res_next[3];
    logic                    deg_reg, deg_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic signed [TAN_W-1:0] out_x_reg, out_x_next;
    logic signed [TAN_W-1:0] out_y_reg, out_y_next;
    logic signed [TAN_W-1:0] out_z_reg, out_z_next;
    logic                    out_deg_reg, out_deg_next;

    // shared units
    mul_op_t          mul_a, mul_b;
    mul_prod_t        mul_prod;
    logic [SUB_W-1:0] sub_a, sub_b;
    logic [SUB_W:0]   sub_diff;
    logic             sub_ge;

    logic                    s_fire;
    logic signed [POS_W-1:0] pos_in [3];
    logic [2:0]              acc_idx;
    logic signed [DET_W-1:0] prod_det;
    logic signed [T_W-1:0]   prod_t;
    logic [S_W-1:0]          prod_s;
    logic [MAG_W-1:0]        n_or;
    logic [MAG_W-1:0]        n_sel;
    logic                    neg_sel;
    logic [QUO_W-1:0]        q_bits;
    logic signed [TAN_W-1:0] q_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign pos_in[0] = s_pos_x;
    assign pos_in[1] = s_pos_y;
    assign pos_in[2] = s_pos_z;

    // ------------------------------------------------------------------
    // Shared multiplier: one product a cycle, result registered and seen in the next cycle.
    // Ops 0..7 in ST_MUL_T: du1*dv2, dv1*du2, then dv2*e1, dv1*e2 per axis.
    // Ops 0..2 in ST_MUL_S: squares of the normalised magnitudes.
    // ------------------------------------------------------------------
    ttuv_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_prod (mul_prod)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL_S) begin
            unique case (op_reg[1:0])
                2'd0: begin
                    mul_a = mul_op_t'(n_reg[0][NRM_W-1:0]);
                    mul_b = mul_op_t'(n_reg[0][NRM_W-1:0]);
                end
                2'd1: begin
                    mul_a = mul_op_t'(n_reg[1][NRM_W-1:0]);
                    mul_b = mul_op_t'(n_reg[1][NRM_W-1:0]);
                end
                2'd2: begin
                    mul_a = mul_op_t'(n_reg[2][NRM_W-1:0]);
                    mul_b = mul_op_t'(n_reg[2][NRM_W-1:0]);
                end
                default: ;  // drain cycle
            endcase
        end else begin
            unique case (op_reg[2:0])
                3'd0: begin mul_a = mul_op_t'(du1_reg); mul_b = mul_op_t'(dv2_reg);   end
                3'd1: begin mul_a = mul_op_t'(dv1_reg); mul_b = mul_op_t'(du2_reg);   end
                3'd2: begin mul_a = mul_op_t'(dv2_reg); mul_b = mul_op_t'(e1_reg[0]); end
                3'd3: begin mul_a = mul_op_t'(dv1_reg); mul_b = mul_op_t'(e2_reg[0]); end
                3'd4: begin mul_a = mul_op_t'(dv2_reg); mul_b = mul_op_t'(e1_reg[1]); end
                3'd5: begin mul_a = mul_op_t'(dv1_reg); mul_b = mul_op_t'(e2_reg[1]); end
                3'd6: begin mul_a = mul_op_t'(dv2_reg); mul_b = mul_op_t'(e1_reg[2]); end
                3'd7: begin mul_a = mul_op_t'(dv1_reg); mul_b = mul_op_t'(e2_reg[2]); end
            endcase
        end
    end

    // product of the previous op, narrowed to the accumulator it feeds
    assign acc_idx  = op_reg[2:0] - 3'd1;
    assign prod_det = DET_W'(mul_prod);
    assign prod_t   = T_W'(mul_prod);
    assign prod_s   = S_W'(mul_prod);

    // ------------------------------------------------------------------
    // Shared subtractor: square-root trial and division trial.
    // Root step: rem:2 next bits of S against root:01.
    // Divide step: rem:next dividend bit against the root.
    // ------------------------------------------------------------------
    always_comb begin
        if (state_reg == ST_SQRT) begin
            sub_a = {rem_reg, s_reg[S_W-1 -: 2]};
            sub_b = SUB_W'({root_reg, 2'b01});
        end else begin
            sub_a = SUB_W'({rem_reg[ROOT_W-1:0], dq_reg[QUO_W-1]});
            sub_b = SUB_W'(root_reg);
        end
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[SUB_W];

    assign n_or   = n_reg[0] | n_reg[1] | n_reg[2];
    assign q_bits = {dq_reg[QUO_W-2:0], sub_ge};
    assign q_ext  = TAN_W'(q_bits);

    always_comb begin
        unique case (comp_reg)
            2'd1:    begin n_sel = n_reg[1]; neg_sel = neg_reg[1]; end
            2'd2:    begin n_sel = n_reg[2]; neg_sel = neg_reg[2]; end
            default: begin n_sel = n_reg[0]; neg_sel = neg_reg[0]; end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        hp_next      = hp_reg;
        hu_next      = hu_reg;
        hv_next      = hv_reg;
        e1_next      = e1_reg;
        e2_next      = e2_reg;
        du1_next     = du1_reg;
        dv1_next     = dv1_reg;
        du2_next     = du2_reg;
        dv2_next     = dv2_reg;
        det_next     = det_reg;
        t_next       = t_reg;
        n_next       = n_reg;
        neg_next     = neg_reg;
        s_next       = s_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        dq_next      = dq_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        comp_next    = comp_reg;
        res_next     = res_reg;
        deg_next     = deg_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_z_next   = out_z_reg;
        out_deg_next = out_deg_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (slot_reg < 2'd2) begin
                        for (int i = 0; i < 3; i++) begin
                            hp_next[slot_reg[0]][i] = pos_in[i];
                        end
                        hu_next[slot_reg[0]] = s_tex_u;
                        hv_next[slot_reg[0]] = s_tex_v;
                        slot_next = slot_reg + 2'd1;
                    end else begin
                        // third vertex closes the triangle
                        for (int i = 0; i < 3; i++) begin
                            e1_next[i] = E_W'(hp_reg[1][i]) - E_W'(hp_reg[0][i]);
                            e2_next[i] = E_W'(pos_in[i]) - E_W'(hp_reg[0][i]);
                        end
                        du1_next   = D_W'(hu_reg[1]) - D_W'(hu_reg[0]);
                        dv1_next   = D_W'(hv_reg[1]) - D_W'(hv_reg[0]);
                        du2_next   = D_W'(s_tex_u) - D_W'(hu_reg[0]);
                        dv2_next   = D_W'(s_tex_v) - D_W'(hv_reg[0]);
                        slot_next  = 2'd0;
                        deg_next   = 1'b0;
                        op_next    = '0;
                        state_next = ST_MUL_T;
                    end
                end
            end

            ST_MUL_T: begin
                // even op loads, odd op subtracts
                if (op_reg != '0) begin
                    unique case (acc_idx[2:1])
                        2'd0: det_next  = acc_idx[0] ? det_reg - prod_det : prod_det;
                        2'd1: t_next[0] = acc_idx[0] ? t_reg[0] - prod_t : prod_t;
                        2'd2: t_next[1] = acc_idx[0] ? t_reg[1] - prod_t : prod_t;
                        2'd3: t_next[2] = acc_idx[0] ? t_reg[2] - prod_t : prod_t;
                    endcase
                end
                op_next = op_reg + 1'b1;
                if (op_reg == OP_W'(N_T_OPS)) begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK: begin
                if (det_reg == '0 || (t_reg[0] == '0 && t_reg[1] == '0 && t_reg[2] == '0)) begin
                    deg_next   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    // sign of the result folds in the sign of det
                    for (int i = 0; i < 3; i++) begin
                        neg_next[i] = t_reg[i][T_W-1] ^ det_reg[DET_W-1];
                        n_next[i]   = t_reg[i][T_W-1] ? MAG_W'(-t_reg[i]) : MAG_W'(t_reg[i]);
                    end
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                // coarse steps while far above range, then single bits
                priority if ((n_or >> (NRM_W + CSH - 1)) != '0) begin
                    for (int i = 0; i < 3; i++) n_next[i] = n_reg[i] >> CSH;
                end else if ((n_or >> NRM_W) != '0) begin
                    for (int i = 0; i < 3; i++) n_next[i] = n_reg[i] >> 1;
                end else begin
                    op_next    = '0;
                    state_next = ST_MUL_S;
                end
            end

            ST_MUL_S: begin
                if (op_reg != '0) begin
                    s_next = (acc_idx[1:0] == 2'd0) ? prod_s : s_reg + prod_s;
                end
                op_next = op_reg + 1'b1;
                if (op_reg == OP_W'(N_S_OPS)) begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end

            ST_SQRT: begin
                rem_next  = sub_ge ? sub_diff[ROOT_W:0] : sub_a[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                s_next    = s_reg << 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_ITER - 1)) begin
                    comp_next  = 2'd0;
                    state_next = ST_DIV_LD;
                end
            end

            ST_DIV_LD: begin
                if (root_reg == '0) begin
                    deg_next   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    // quotient fits QUO_W bits, so the top of the dividend starts as remainder
                    rem_next   = (ROOT_W + 1)'(n_sel[NRM_W-1:1]);
                    dq_next    = {n_sel[0], FRAC_W'(0)};
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV: begin
                rem_next = sub_ge ? sub_diff[ROOT_W:0] : sub_a[ROOT_W:0];
                dq_next  = q_bits;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                    res_next[comp_reg] = neg_sel ? -q_ext : q_ext;
                    if (comp_reg == 2'd2) begin
                        state_next = ST_FIN;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_DIV_LD;
                    end
                end
            end

            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_x_next   = deg_reg ? '0 : res_reg[0];
                    out_y_next   = deg_reg ? '0 : res_reg[1];
                    out_z_next   = deg_reg ? '0 : res_reg[2];
                    out_deg_next = deg_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= 2'd0;
            op_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hp_reg      <= hp_next;
        hu_reg      <= hu_next;
        hv_reg      <= hv_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        du1_reg     <= du1_next;
        dv1_reg     <= dv1_next;
        du2_reg     <= du2_next;
        dv2_reg     <= dv2_next;
        det_reg     <= det_next;
        t_reg       <= t_next;
        n_reg       <= n_next;
        neg_reg     <= neg_next;
        s_reg       <= s_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        dq_reg      <= dq_next;
        cnt_reg     <= cnt_next;
        comp_reg    <= comp_next;
        res_reg     <= res_next;
        deg_reg     <= deg_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_z_reg   <= out_z_next;
        out_deg_reg <= out_deg_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_tangent_x  = out_x_reg;
    assign m_tangent_y  = out_y_reg;
    assign m_tangent_z  = out_z_reg;
    assign m_degenerate = out_deg_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // a new word only ever comes from the hand-over state
    a_word_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> $past(state_reg == ST_FIN))
        else $error("output word raised outside hand-over");

    // third vertex starts the product sequence
    a_third_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && slot_reg == 2'd2) |=> (state_reg == ST_MUL_T && op_reg == '0))
        else $error("third vertex did not start the sequence");

    // a degenerate word carries a zero tangent
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |->
        (m_tangent_x == '0 && m_tangent_y == '0 && m_tangent_z == '0))
        else $error("degenerate word with non-zero tangent");

    // unit tangent stays within one
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_degenerate) |->
        (m_tangent_x <= ONE_Q && m_tangent_x >= -ONE_Q &&
         m_tangent_y <= ONE_Q && m_tangent_y >= -ONE_Q &&
         m_tangent_z <= ONE_Q && m_tangent_z >= -ONE_Q))
        else $error("tangent component above one");

    // division never runs against a zero root
    a_div_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (root_reg != '0))
        else $error("division by zero root");

endmodule
